>>> rtl/tekd_pkg.sv
// Package: shared types, byte constants and key codes for the escape key decoder.
package tekd_pkg;

    // Special input bytes
    localparam logic [7:0] C_ESC       = 8'h1B;
    localparam logic [7:0] C_LOWER_F   = 8'h66; // 'f'
    localparam logic [7:0] C_LOWER_B   = 8'h62; // 'b'
    localparam logic [7:0] C_LOWER_V   = 8'h76; // 'v'
    localparam logic [7:0] C_LBRACKET  = 8'h5B; // '['
    localparam logic [7:0] C_UPPER_O   = 8'h4F; // 'O'
    localparam logic [7:0] C_TILDE     = 8'h7E; // '~'
    localparam logic [7:0] C_SEMICOLON = 8'h3B; // ';'
    localparam logic [7:0] C_DIGIT_0   = 8'h30; // '0'
    localparam logic [7:0] C_DIGIT_1   = 8'h31; // '1'
    localparam logic [7:0] C_DIGIT_3   = 8'h33; // '3'
    localparam logic [7:0] C_DIGIT_5   = 8'h35; // '5'
    localparam logic [7:0] C_DIGIT_6   = 8'h36; // '6'
    localparam logic [7:0] C_DIGIT_9   = 8'h39; // '9'
    localparam logic [7:0] C_UPPER_A   = 8'h41; // 'A'
    localparam logic [7:0] C_UPPER_B   = 8'h42; // 'B'
    localparam logic [7:0] C_UPPER_C   = 8'h43; // 'C'
    localparam logic [7:0] C_UPPER_D   = 8'h44; // 'D'
    localparam logic [7:0] C_UPPER_H   = 8'h48; // 'H'
    localparam logic [7:0] C_UPPER_F   = 8'h46; // 'F'

    // Key codes
    localparam logic [4:0] K_PLAIN = 5'd0;
    localparam logic [4:0] K_ESC   = 5'd1;
    localparam logic [4:0] K_ALT_F = 5'd2;
    localparam logic [4:0] K_ALT_B = 5'd3;
    localparam logic [4:0] K_ALT_V = 5'd4;
    localparam logic [4:0] K_DEL   = 5'd5;
    localparam logic [4:0] K_PGUP  = 5'd6;
    localparam logic [4:0] K_PGDN  = 5'd7;
    localparam logic [4:0] K_CTRL0 = 5'd8;
    localparam logic [4:0] K_NAV0  = 5'd14;

    // Navigation letter offsets within a key group
    localparam logic [2:0] NAV_HOME = 3'd4;
    localparam logic [2:0] NAV_END  = 3'd5;

    // Request types
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // Parser phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ESC   = 3'd1,
        PH_INTRO = 3'd2,
        PH_PARAM = 3'd3,
        PH_SEMI  = 3'd4,
        PH_MOD   = 3'd5
    } t_phase;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [4:0] key_code;
        logic [7:0] plain_byte;
    } t_out_item;

    // Decode result of one item
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_dec_res;

    // Navigation letter lookup
    typedef struct packed {
        logic       hit;
        logic [2:0] off;
    } t_nav;

    function automatic t_nav nav_decode(input logic [7:0] b);
        t_nav r;
        r.hit = 1'b1;
        r.off = 3'd0;
        unique case (b)
            C_UPPER_A: r.off = 3'd0;
            C_UPPER_B: r.off = 3'd1;
            C_UPPER_C: r.off = 3'd2;
            C_UPPER_D: r.off = 3'd3;
            C_UPPER_H: r.off = NAV_HOME;
            C_UPPER_F: r.off = NAV_END;
            default:   r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/tekd_parser.sv
// Sequence parser: phase and captured bytes, plus the key decode of one item.
module tekd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tekd_pkg::t_in_item  i_item,
    input  logic                i_fire,
    output tekd_pkg::t_dec_res  o_res
);

    tekd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_intro, n_intro;
    logic [7:0]       r_param, n_param;
    logic [7:0]       r_mod, n_mod;

    logic             w_to;
    logic [7:0]       w_b;
    tekd_pkg::t_nav   w_nav;
    logic             w_alt_hit;
    logic [4:0]       w_alt_key;
    logic             w_csi;
    logic             w_digit;
    logic             w_intro_hit;
    logic [4:0]       w_intro_key;
    logic             w_param_hit;
    logic [4:0]       w_param_key;
    logic             w_mod_hit;

    assign w_to  = (i_item.req_type == tekd_pkg::REQ_TIMEOUT);
    assign w_b   = i_item.rx_byte;
    assign w_nav = tekd_pkg::nav_decode(w_b);

    // Alt keys after a lone ESC
    always_comb begin
        w_alt_hit = 1'b1;
        w_alt_key = tekd_pkg::K_ALT_F;
        unique case (w_b)
            tekd_pkg::C_LOWER_F: w_alt_key = tekd_pkg::K_ALT_F;
            tekd_pkg::C_LOWER_B: w_alt_key = tekd_pkg::K_ALT_B;
            tekd_pkg::C_LOWER_V: w_alt_key = tekd_pkg::K_ALT_V;
            default:             w_alt_hit = 1'b0;
        endcase
    end

    // Final byte after the intro byte: CSI letters or SS3 Home/End
    assign w_csi   = (r_intro == tekd_pkg::C_LBRACKET);
    assign w_digit = (w_b >= tekd_pkg::C_DIGIT_0) && (w_b <= tekd_pkg::C_DIGIT_9);
    always_comb begin
        w_intro_hit = 1'b0;
        w_intro_key = tekd_pkg::K_NAV0 + {2'b00, w_nav.off};
        if (w_csi) begin
            w_intro_hit = w_nav.hit;
        end else if (r_intro == tekd_pkg::C_UPPER_O) begin
            w_intro_hit = w_nav.hit && (w_nav.off == tekd_pkg::NAV_HOME ||
                                        w_nav.off == tekd_pkg::NAV_END);
        end
    end

    // Tilde-terminated keys
    always_comb begin
        w_param_hit = (w_b == tekd_pkg::C_TILDE);
        w_param_key = tekd_pkg::K_DEL;
        unique case (r_param)
            tekd_pkg::C_DIGIT_3: w_param_key = tekd_pkg::K_DEL;
            tekd_pkg::C_DIGIT_5: w_param_key = tekd_pkg::K_PGUP;
            tekd_pkg::C_DIGIT_6: w_param_key = tekd_pkg::K_PGDN;
            default:             w_param_hit = 1'b0;
        endcase
    end

    // Ctrl modifier sequence
    assign w_mod_hit = (r_param == tekd_pkg::C_DIGIT_1) && (r_mod == tekd_pkg::C_DIGIT_5)
                       && w_nav.hit;

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_intro = r_intro;
        n_param = r_param;
        n_mod   = r_mod;
        unique case (r_phase)
            tekd_pkg::PH_ESC: begin
                if (w_to || w_alt_hit) begin
                    n_phase = tekd_pkg::PH_IDLE;
                end else begin
                    n_intro = w_b;
                    n_phase = tekd_pkg::PH_INTRO;
                end
            end
            tekd_pkg::PH_INTRO: begin
                if (w_to) begin
                    n_phase = tekd_pkg::PH_IDLE;
                end else if (w_csi && w_digit) begin
                    n_param = w_b;
                    n_phase = tekd_pkg::PH_PARAM;
                end else if (w_intro_hit) begin
                    n_phase = tekd_pkg::PH_IDLE;
                end else begin
                    n_phase = tekd_pkg::PH_ESC;
                end
            end
            tekd_pkg::PH_PARAM: begin
                if (w_to || w_param_hit) begin
                    n_phase = tekd_pkg::PH_IDLE;
                end else if (w_b == tekd_pkg::C_SEMICOLON) begin
                    n_phase = tekd_pkg::PH_SEMI;
                end else begin
                    n_phase = tekd_pkg::PH_ESC;
                end
            end
            tekd_pkg::PH_SEMI: begin
                if (w_to) begin
                    n_phase = tekd_pkg::PH_IDLE;
                end else begin
                    n_mod   = w_b;
                    n_phase = tekd_pkg::PH_MOD;
                end
            end
            tekd_pkg::PH_MOD: begin
                if (w_to || w_mod_hit) begin
                    n_phase = tekd_pkg::PH_IDLE;
                end else begin
                    n_phase = tekd_pkg::PH_ESC;
                end
            end
            default: begin
                if (!w_to && w_b == tekd_pkg::C_ESC) begin
                    n_phase = tekd_pkg::PH_ESC;
                end else begin
                    n_phase = tekd_pkg::PH_IDLE;
                end
            end
        endcase
    end

    // Result of the current item
    always_comb begin
        o_res.valid           = 1'b0;
        o_res.item.key_code   = tekd_pkg::K_PLAIN;
        o_res.item.plain_byte = 8'd0;
        unique case (r_phase)
            tekd_pkg::PH_ESC, tekd_pkg::PH_INTRO, tekd_pkg::PH_PARAM,
            tekd_pkg::PH_SEMI, tekd_pkg::PH_MOD: begin
                if (w_to) begin
                    o_res.valid         = 1'b1;
                    o_res.item.key_code = tekd_pkg::K_ESC;
                end else if (r_phase == tekd_pkg::PH_ESC && w_alt_hit) begin
                    o_res.valid         = 1'b1;
                    o_res.item.key_code = w_alt_key;
                end else if (r_phase == tekd_pkg::PH_INTRO && !(w_csi && w_digit)
                             && w_intro_hit) begin
                    o_res.valid         = 1'b1;
                    o_res.item.key_code = w_intro_key;
                end else if (r_phase == tekd_pkg::PH_PARAM && w_param_hit) begin
                    o_res.valid         = 1'b1;
                    o_res.item.key_code = w_param_key;
                end else if (r_phase == tekd_pkg::PH_MOD && w_mod_hit) begin
                    o_res.valid         = 1'b1;
                    o_res.item.key_code = tekd_pkg::K_CTRL0 + {2'b00, w_nav.off};
                end
            end
            default: begin
                // Idle: any byte but ESC is a plain key, timeout is ignored
                if (!w_to && w_b != tekd_pkg::C_ESC) begin
                    o_res.valid           = 1'b1;
                    o_res.item.plain_byte = w_b;
                end
            end
        endcase
    end

    // State update on each consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tekd_pkg::PH_IDLE;
            r_intro <= 8'd0;
            r_param <= 8'd0;
            r_mod   <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_intro <= n_intro;
            r_param <= n_param;
            r_mod   <= n_mod;
        end
    end

endmodule

>>> rtl/tekd_out_reg.sv
// Result register: holds one decoded key until the downstream transfer.
module tekd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tekd_pkg::t_out_item i_item,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_stall,
    output tekd_pkg::t_out_item o_item
);

    logic                r_valid, n_valid;
    tekd_pkg::t_out_item r_item;

    // Free when empty or emptying this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/terminal_escape_key_decoder.sv
// Top level: input register, sequence parser and result register of the key decoder.
//
// Decodes a stream of terminal bytes and timeout events into keys: plain bytes,
// bare ESC, Alt f/b/v, arrows, Home/End, Delete, Page Up/Down and Ctrl
// arrows/Home/End. One item is taken per clock while the input is not stalled;
// each item waits in the input register, where the parser decodes it against
// the current phase, and a key, if any, is loaded into the result register
// when the item leaves the input register. Items that yield no key (ESC,
// sequence bytes, ignored timeouts) never wait on the output side; an item that
// yields a key waits only while the result register is full and stalled.
module terminal_escape_key_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tekd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tekd_pkg::t_out_item o_out_item
);

    logic               r_in_valid, n_in_valid;
    tekd_pkg::t_in_item r_in_item;
    tekd_pkg::t_dec_res w_res;
    logic               w_out_free;
    logic               w_advance;
    logic               w_in_xfer;

    // Input item leaves the register when its key has somewhere to go or it yields no key
    assign w_advance  = r_in_valid && (w_out_free || !w_res.valid);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // Input register
    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_xfer) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    tekd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_in_item),
        .i_fire  (w_advance),
        .o_res   (w_res)
    );

    tekd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_res.valid),
        .i_item  (w_res.item),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // A held result is never overwritten by a new key
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !(w_advance && w_res.valid))
        else $error("result register overwritten while stalled");

    // Input side stalls only behind a waiting item
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && w_res.valid))
        else $error("input stalled without a pending key");

    // Only plain keys carry a byte
    a_plain_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_res.item.key_code != tekd_pkg::K_PLAIN)
        |-> (w_res.item.plain_byte == 8'd0))
        else $error("non-plain key carries a byte");

    // A key loaded into the result register appears at the output next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_res.valid) |=> (o_out_valid && o_out_item == $past(w_res.item)))
        else $error("loaded key not presented");
`endif

endmodule
